[design/gtkm_pkg.sv]
// ----------------------------------------------------------------------------
// gtkm_pkg
// Shared codes, types and lookup functions for the gamepad event converter.
// ----------------------------------------------------------------------------
package gtkm_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int TIME_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_W  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_H  = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OVERLAY_W = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OVERLAY_H = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OVERLAY_ON = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL  = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_LO   = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_HI   = 4'd7;

    localparam logic [10:0] RST_SCREEN_W  = 11'd320;
    localparam logic [10:0] RST_SCREEN_H  = 11'd200;
    localparam logic [10:0] RST_OVERLAY_W = 11'd480;
    localparam logic [10:0] RST_OVERLAY_H = 11'd272;
    localparam logic [9:0]  RST_INTERVAL  = 10'd40;
    localparam logic [7:0]  RST_DEAD_LO   = 8'd100;
    localparam logic [7:0]  RST_DEAD_HI   = 8'd155;
    localparam logic [10:0] WIDE_SCREEN_W = 11'd640;
    localparam int          CURSOR_RST_X  = 240;
    localparam int          CURSOR_RST_Y  = 136;

    localparam int BTN_UP       = 0;
    localparam int BTN_RIGHT    = 1;
    localparam int BTN_DOWN     = 2;
    localparam int BTN_LEFT     = 3;
    localparam int BTN_CROSS    = 4;
    localparam int BTN_CIRCLE   = 5;
    localparam int BTN_LTRIG    = 6;
    localparam int BTN_RTRIG    = 7;
    localparam int BTN_START    = 8;
    localparam int BTN_SELECT   = 9;
    localparam int BTN_SQUARE   = 10;
    localparam int BTN_TRIANGLE = 11;

    localparam logic [2:0] EV_KEY_DOWN   = 3'd0;
    localparam logic [2:0] EV_KEY_UP     = 3'd1;
    localparam logic [2:0] EV_LEFT_DOWN  = 3'd2;
    localparam logic [2:0] EV_LEFT_UP    = 3'd3;
    localparam logic [2:0] EV_RIGHT_DOWN = 3'd4;
    localparam logic [2:0] EV_RIGHT_UP   = 3'd5;
    localparam logic [2:0] EV_MOUSE_MOVE = 3'd6;

    localparam logic [3:0] KEY_NONE   = 4'd0;
    localparam logic [3:0] KEY_PAD1   = 4'd1;
    localparam logic [3:0] KEY_PAD2   = 4'd2;
    localparam logic [3:0] KEY_PAD3   = 4'd3;
    localparam logic [3:0] KEY_PAD4   = 4'd4;
    localparam logic [3:0] KEY_PAD6   = 4'd5;
    localparam logic [3:0] KEY_PAD7   = 4'd6;
    localparam logic [3:0] KEY_PAD8   = 4'd7;
    localparam logic [3:0] KEY_PAD9   = 4'd8;
    localparam logic [3:0] KEY_ESC    = 4'd9;
    localparam logic [3:0] KEY_F5     = 4'd10;
    localparam logic [3:0] KEY_PERIOD = 4'd11;
    localparam logic [3:0] KEY_RETURN = 4'd12;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] key;
        logic       ctrl;
        logic       shift;
    } t_evt_ctl;

    function automatic logic [8:0] ascii_of(input logic [3:0] key);
        logic [8:0] a;
        unique case (key)
            KEY_PAD1:   a = 9'd49;
            KEY_PAD2:   a = 9'd50;
            KEY_PAD3:   a = 9'd51;
            KEY_PAD4:   a = 9'd52;
            KEY_PAD6:   a = 9'd54;
            KEY_PAD7:   a = 9'd55;
            KEY_PAD8:   a = 9'd56;
            KEY_PAD9:   a = 9'd57;
            KEY_ESC:    a = 9'd27;
            KEY_F5:     a = 9'd319;
            KEY_PERIOD: a = 9'd46;
            KEY_RETURN: a = 9'd13;
            default:    a = 9'd0;
        endcase
        return a;
    endfunction

    // keypad key for a held direction, -1..1 on each axis
    function automatic logic [3:0] dir_key(input logic signed [1:0] x,
                                           input logic signed [1:0] y);
        logic [3:0] k;
        if (x[1]) begin
            k = y[1] ? KEY_PAD1 : ((y == 2'sd0) ? KEY_PAD4 : KEY_PAD7);
        end else if (x == 2'sd0) begin
            k = y[1] ? KEY_PAD2 : KEY_PAD8;
        end else begin
            k = y[1] ? KEY_PAD3 : ((y == 2'sd0) ? KEY_PAD6 : KEY_PAD9);
        end
        return k;
    endfunction

endpackage

[design/gtkm_if.sv]
// ----------------------------------------------------------------------------
// gtkm_if
// Channel interfaces: gamepad samples, key and mouse events, register writes.
// ----------------------------------------------------------------------------
interface gtkm_smp_if #(parameter int TIME_BITS = gtkm_pkg::TIME_BITS_DEF);
    logic                 valid;
    logic                 ready;
    logic [11:0]          button_bits;
    logic [7:0]           stick_x;
    logic [7:0]           stick_y;
    logic [TIME_BITS-1:0] now_ms;

    modport source (output valid, button_bits, stick_x, stick_y, now_ms, input ready);
    modport sink   (input valid, button_bits, stick_x, stick_y, now_ms, output ready);
endinterface

interface gtkm_evt_if #(parameter int COORD_BITS = gtkm_pkg::COORD_BITS_DEF);
    logic                  valid;
    logic                  ready;
    logic [2:0]            event_kind;
    logic [3:0]            key_code;
    logic [8:0]            ascii_code;
    logic                  flag_ctrl;
    logic                  flag_shift;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;

    modport source (output valid, event_kind, key_code, ascii_code, flag_ctrl, flag_shift,
                    cursor_x, cursor_y, input ready);
    modport sink   (input valid, event_kind, key_code, ascii_code, flag_ctrl, flag_shift,
                    cursor_x, cursor_y, output ready);
endinterface

interface gtkm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gtkm_pkg::CFG_IDX_BITS-1:0]  index;
    logic [gtkm_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/gtkm_front.sv]
// ----------------------------------------------------------------------------
// gtkm_front
// Takes one sample a cycle unless the queue is full, updates pad and cursor
// state, classifies the resulting event word and holds the config registers.
// ----------------------------------------------------------------------------
module gtkm_front #(
    parameter int COORD_BITS = gtkm_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = gtkm_pkg::TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gtkm_cfg_if.sink              i_cfg,
    gtkm_smp_if.sink              i_smp,
    input  logic                  i_full,
    output logic                  o_push,
    output gtkm_pkg::t_evt_ctl    o_evt,
    output logic [COORD_BITS-1:0] o_cx,
    output logic [COORD_BITS-1:0] o_cy
);
    import gtkm_pkg::*;

    localparam int SW = ((COORD_BITS > 11) ? COORD_BITS : 11) + 2;
    localparam logic signed [SW-1:0] CMAX = SW'((1 << COORD_BITS) - 1);

    logic [10:0] r_screen_w, r_screen_h, r_overlay_w, r_overlay_h;
    logic        r_overlay_on;
    logic [9:0]  r_interval;
    logic [7:0]  r_dead_lo, r_dead_hi;

    logic [11:0]           r_rec, n_rec;
    logic signed [1:0]     r_hx, n_hx, r_hy, n_hy;
    logic [COORD_BITS-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [TIME_BITS-1:0]  r_last, n_last;

    logic                  acc, emit, rt, dir_chg, late, moved;
    logic [11:0]           btn, chg;
    logic [2:0]            sum_x, sum_y;
    logic signed [1:0]     nx, ny;
    logic signed [9:0]     ax, ay, step_x, step_y;
    logic signed [SW-1:0]  px, py;
    logic [COORD_BITS-1:0] cx_new, cy_new;
    logic [TIME_BITS-1:0]  elapsed;
    t_evt_ctl              ev;

    function automatic logic signed [9:0] stick_off(input logic [7:0] v,
                                                    input logic [7:0] lo,
                                                    input logic [7:0] hi);
        logic signed [9:0] r;
        r = '0;
        if (v < lo) begin
            r = $signed({2'b00, v}) - $signed({2'b00, lo});
        end else if (v > hi) begin
            r = $signed({2'b00, v}) - $signed({2'b00, hi});
        end
        return r;
    endfunction

    function automatic logic signed [9:0] step_of(input logic signed [9:0] a,
                                                  input logic trig,
                                                  input logic sh2);
        logic signed [9:0] r;
        if (trig) begin
            r = (a > 10'sd0) ? 10'sd1 : ((a < 10'sd0) ? -10'sd1 : 10'sd0);
        end else begin
            r = sh2 ? (a >>> 2) : (a >>> 3);
        end
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [SW-1:0] v,
                                                         input logic [10:0] lim);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] hv;
        hi = SW'($signed({{(SW-11){1'b0}}, lim}) - 1);
        if (hi > CMAX) begin
            hi = CMAX;
        end
        hv = v;
        if (hv > hi) begin
            hv = hi;
        end
        if (hv[SW-1]) begin
            hv = '0;
        end
        return hv[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [1:0] sat1(input logic [2:0] s);
        logic signed [1:0] r;
        if (s == 3'b010) begin
            r = 2'sd1;
        end else if (s == 3'b110) begin
            r = -2'sd1;
        end else begin
            r = s[1:0];
        end
        return r;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_smp.ready = !i_full;
    assign acc = i_smp.valid && i_smp.ready;

    assign btn = i_smp.button_bits;
    assign chg = btn ^ r_rec;
    assign rt  = btn[BTN_RTRIG];

    // rotated d-pad sums
    assign sum_x = 3'(btn[BTN_RIGHT]) + 3'(btn[BTN_UP] & rt)
                 - 3'(btn[BTN_LEFT]) - 3'(btn[BTN_DOWN] & rt);
    assign sum_y = 3'(btn[BTN_UP]) + 3'(btn[BTN_LEFT] & rt)
                 - 3'(btn[BTN_DOWN]) - 3'(btn[BTN_RIGHT] & rt);
    assign nx = sat1(sum_x);
    assign ny = sat1(sum_y);
    assign dir_chg = (nx != r_hx) || (ny != r_hy);

    assign elapsed = i_smp.now_ms - r_last;
    assign late    = elapsed > {{(TIME_BITS-10){1'b0}}, r_interval};

    assign ax = stick_off(i_smp.stick_x, r_dead_lo, r_dead_hi);
    assign ay = stick_off(i_smp.stick_y, r_dead_lo, r_dead_hi);
    assign step_x = step_of(ax, rt, r_screen_w == WIDE_SCREEN_W);
    assign step_y = step_of(ay, rt, r_screen_w == WIDE_SCREEN_W);
    assign px = $signed({{(SW-COORD_BITS){1'b0}}, r_cx}) + $signed({{(SW-10){step_x[9]}}, step_x});
    assign py = $signed({{(SW-COORD_BITS){1'b0}}, r_cy}) + $signed({{(SW-10){step_y[9]}}, step_y});
    assign cx_new = clamp_axis(px, r_overlay_on ? r_overlay_w : r_screen_w);
    assign cy_new = clamp_axis(py, r_overlay_on ? r_overlay_h : r_screen_h);
    assign moved  = (cx_new != r_cx) || (cy_new != r_cy);

    always_comb begin
        n_rec  = r_rec;
        n_hx   = r_hx;
        n_hy   = r_hy;
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_last = r_last;
        emit   = 1'b0;
        ev     = '0;
        if (dir_chg) begin
            emit  = 1'b1;
            n_rec = btn;
            if (r_hx == 2'sd0 && r_hy == 2'sd0) begin
                ev.kind = EV_KEY_DOWN;
                ev.key  = dir_key(nx, ny);
                n_hx    = nx;
                n_hy    = ny;
            end else begin
                ev.kind = EV_KEY_UP;
                ev.key  = dir_key(r_hx, r_hy);
                n_hx    = '0;
                n_hy    = '0;
            end
        end else if (|chg[11:4]) begin
            emit  = 1'b1;
            n_rec = btn;
            if (chg[BTN_CROSS]) begin
                ev.kind = btn[BTN_CROSS] ? EV_LEFT_DOWN : EV_LEFT_UP;
            end else if (chg[BTN_CIRCLE]) begin
                ev.kind = btn[BTN_CIRCLE] ? EV_RIGHT_DOWN : EV_RIGHT_UP;
            end else begin
                ev.kind = (|(chg & btn)) ? EV_KEY_DOWN : EV_KEY_UP;
                if (chg[BTN_LTRIG]) begin
                    ev.key = KEY_ESC;
                end else if (chg[BTN_START]) begin
                    ev.key  = KEY_F5;
                    ev.ctrl = rt;
                end else if (chg[BTN_SQUARE]) begin
                    ev.key = KEY_PERIOD;
                end else if (chg[BTN_TRIANGLE]) begin
                    ev.key = KEY_RETURN;
                end else begin
                    ev.shift = rt;
                end
            end
        end else if (late) begin
            n_last = i_smp.now_ms;
            if (ax != 10'sd0 || ay != 10'sd0) begin
                n_rec = btn;
                if (moved) begin
                    n_cx    = cx_new;
                    n_cy    = cy_new;
                    emit    = 1'b1;
                    ev.kind = EV_MOUSE_MOVE;
                end
            end
        end
    end

    assign o_push = acc && emit;
    assign o_evt  = ev;
    assign o_cx   = n_cx;
    assign o_cy   = n_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w   <= RST_SCREEN_W;
            r_screen_h   <= RST_SCREEN_H;
            r_overlay_w  <= RST_OVERLAY_W;
            r_overlay_h  <= RST_OVERLAY_H;
            r_overlay_on <= 1'b0;
            r_interval   <= RST_INTERVAL;
            r_dead_lo    <= RST_DEAD_LO;
            r_dead_hi    <= RST_DEAD_HI;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_SCREEN_W:   r_screen_w   <= i_cfg.data;
                CFG_SCREEN_H:   r_screen_h   <= i_cfg.data;
                CFG_OVERLAY_W:  r_overlay_w  <= i_cfg.data;
                CFG_OVERLAY_H:  r_overlay_h  <= i_cfg.data;
                CFG_OVERLAY_ON: r_overlay_on <= i_cfg.data[0];
                CFG_INTERVAL:   r_interval   <= i_cfg.data[9:0];
                CFG_DEAD_LO:    r_dead_lo    <= i_cfg.data[7:0];
                CFG_DEAD_HI:    r_dead_hi    <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec  <= '0;
            r_hx   <= '0;
            r_hy   <= '0;
            r_cx   <= COORD_BITS'(CURSOR_RST_X);
            r_cy   <= COORD_BITS'(CURSOR_RST_Y);
            r_last <= '0;
        end else if (acc) begin
            r_rec  <= n_rec;
            r_hx   <= n_hx;
            r_hy   <= n_hy;
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_last <= n_last;
        end
    end

    a_hx_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hx != 2'b10) else $error("held x direction out of range");
    a_hy_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hy != 2'b10) else $error("held y direction out of range");
    a_last_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_last)) else $error("check time moved without a word");
endmodule

[design/gtkm_fifo.sv]
// ----------------------------------------------------------------------------
// gtkm_fifo
// Short queue of event words between the classifier and the output stage.
// ----------------------------------------------------------------------------
module gtkm_fifo #(
    parameter int WIDTH = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import gtkm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PLAST = PW'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_count;

    assign o_full  = r_count == CW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PLAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PLAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a word");
endmodule

[design/gtkm_back.sv]
// ----------------------------------------------------------------------------
// gtkm_back
// Output stage: takes event words from the queue, maps key codes to ascii
// and holds each word until the receiver takes it.
// ----------------------------------------------------------------------------
module gtkm_back #(
    parameter int COORD_BITS = gtkm_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  gtkm_pkg::t_evt_ctl    i_q_evt,
    input  logic [COORD_BITS-1:0] i_q_cx,
    input  logic [COORD_BITS-1:0] i_q_cy,
    output logic                  o_pop,
    gtkm_evt_if.source            o_evt
);
    import gtkm_pkg::*;

    logic                  r_valid;
    t_evt_ctl              r_ctl;
    logic [8:0]            r_ascii;
    logic [COORD_BITS-1:0] r_cx, r_cy;

    assign o_pop = i_q_valid && (!r_valid || o_evt.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl   <= i_q_evt;
            r_ascii <= ascii_of(i_q_evt.key);
            r_cx    <= i_q_cx;
            r_cy    <= i_q_cy;
        end
    end

    assign o_evt.valid      = r_valid;
    assign o_evt.event_kind = r_ctl.kind;
    assign o_evt.key_code   = r_ctl.key;
    assign o_evt.ascii_code = r_ascii;
    assign o_evt.flag_ctrl  = r_ctl.ctrl;
    assign o_evt.flag_shift = r_ctl.shift;
    assign o_evt.cursor_x   = r_cx;
    assign o_evt.cursor_y   = r_cy;
endmodule

[design/gamepad_to_key_mouse_events_unit.sv]
// ----------------------------------------------------------------------------
// gamepad_to_key_mouse_events_unit
// Turns gamepad samples into keypad, key and mouse events.
// ----------------------------------------------------------------------------
// i_smp carries one gamepad sample per word: buttons, two stick axes and a
// millisecond time. Each sample yields at most one event word on o_evt:
// d-pad key down/up, mouse button, mapped key with ctrl/shift, or a cursor
// move once per check interval. i_cfg writes the surface sizes, overlay
// select, check interval and stick dead zone, and is always ready.
// The classifier takes one sample per cycle while the queue is not full; its
// next state comes from combinational compare, shift and clamp logic, so
// samples may follow back to back. Each event word is registered in the queue
// and then in the output register, which sit between the classifier and the
// receiver: while o_evt is stalled samples keep flowing until the four-word
// queue fills, then i_smp.ready drops until the receiver takes a word.
// Reset restores the register defaults, places the cursor at 240,136,
// clears the recorded buttons, held direction and check time, and empties
// the queue and output stage.
// ----------------------------------------------------------------------------
module gamepad_to_key_mouse_events_unit #(
    parameter int COORD_BITS = gtkm_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = gtkm_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gtkm_cfg_if.sink    i_cfg,
    gtkm_smp_if.sink    i_smp,
    gtkm_evt_if.source  o_evt
);
    import gtkm_pkg::*;

    localparam int QW = $bits(t_evt_ctl) + 2 * COORD_BITS;

    logic                  q_full, q_push, q_pop, q_valid;
    t_evt_ctl              f_evt, q_evt;
    logic [COORD_BITS-1:0] f_cx, f_cy, q_cx, q_cy;
    logic [QW-1:0]         q_data;

    gtkm_front #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_smp   (i_smp),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_evt   (f_evt),
        .o_cx    (f_cx),
        .o_cy    (f_cy)
    );

    gtkm_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_evt, f_cx, f_cy}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {q_evt, q_cx, q_cy} = q_data;

    gtkm_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_evt   (q_evt),
        .i_q_cx    (q_cx),
        .i_q_cy    (q_cy),
        .o_pop     (q_pop),
        .o_evt     (o_evt)
    );
endmodule

[verif/gamepad_to_key_mouse_events_unit_tb.sv]
// ----------------------------------------------------------------------------
// gamepad_to_key_mouse_events_unit_tb
// Self-checking bench for the gamepad to key and mouse event converter.
// A directed run covers the d-pad (plain, rotated, direct swap, saturated),
// every other button, stick moves and time wrap. Random samples then run
// under several register settings. A predictor in the bench works out the
// event word for each accepted sample, and every event word taken from the
// block is compared field by field with the oldest prediction. Both
// channels stall at random, except for one phase with no stalls.
// ----------------------------------------------------------------------------
module gamepad_to_key_mouse_events_unit_tb;
    import gtkm_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 118;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 4'd15;

    localparam logic [11:0] M_UP       = 12'd1 << BTN_UP;
    localparam logic [11:0] M_RIGHT    = 12'd1 << BTN_RIGHT;
    localparam logic [11:0] M_DOWN     = 12'd1 << BTN_DOWN;
    localparam logic [11:0] M_LEFT     = 12'd1 << BTN_LEFT;
    localparam logic [11:0] M_CROSS    = 12'd1 << BTN_CROSS;
    localparam logic [11:0] M_CIRCLE   = 12'd1 << BTN_CIRCLE;
    localparam logic [11:0] M_LTRIG    = 12'd1 << BTN_LTRIG;
    localparam logic [11:0] M_RTRIG    = 12'd1 << BTN_RTRIG;
    localparam logic [11:0] M_START    = 12'd1 << BTN_START;
    localparam logic [11:0] M_SELECT   = 12'd1 << BTN_SELECT;
    localparam logic [11:0] M_SQUARE   = 12'd1 << BTN_SQUARE;
    localparam logic [11:0] M_TRIANGLE = 12'd1 << BTN_TRIANGLE;

    typedef struct packed {
        logic [11:0] buttons;
        logic [7:0]  sx;
        logic [7:0]  sy;
        logic [31:0] now;
    } t_pad_sample;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] key;
        logic [8:0] ascii;
        logic       ctrl;
        logic       shift;
        logic [9:0] cx;
        logic [9:0] cy;
    } t_event_word;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] val;
    } t_reg_write;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gtkm_smp_if #(.TIME_BITS(32))  smp_if ();
    gtkm_evt_if #(.COORD_BITS(10)) evt_if ();
    gtkm_cfg_if                    cfg_if ();

    gamepad_to_key_mouse_events_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_smp   (smp_if),
        .o_evt   (evt_if)
    );

    always #2 i_clk = ~i_clk;

    // register shadows
    logic [10:0] reg_screen_w   = RST_SCREEN_W;
    logic [10:0] reg_screen_h   = RST_SCREEN_H;
    logic [10:0] reg_overlay_w  = RST_OVERLAY_W;
    logic [10:0] reg_overlay_h  = RST_OVERLAY_H;
    logic        reg_overlay_on = 1'b0;
    logic [9:0]  reg_interval   = RST_INTERVAL;
    logic [7:0]  reg_dead_lo    = RST_DEAD_LO;
    logic [7:0]  reg_dead_hi    = RST_DEAD_HI;

    // converter state
    logic [11:0] rec_buttons = '0;
    int          held_x      = 0;
    int          held_y      = 0;
    int          cur_x       = CURSOR_RST_X;
    int          cur_y       = CURSOR_RST_Y;
    logic [31:0] last_check  = '0;

    t_pad_sample sample_queue[$];
    t_event_word expected_events[$];
    t_reg_write  reg_writes[$];
    t_pad_sample cur_sample;

    logic [11:0] pad_btn   = '0;
    logic [31:0] clock_ms  = '0;
    bit          steady    = 1'b0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    function automatic logic [3:0] pad_key_of(input int x, input int y);
        if (x < 0) return (y < 0) ? KEY_PAD1 : ((y == 0) ? KEY_PAD4 : KEY_PAD7);
        if (x == 0) return (y < 0) ? KEY_PAD2 : KEY_PAD8;
        return (y < 0) ? KEY_PAD3 : ((y == 0) ? KEY_PAD6 : KEY_PAD9);
    endfunction

    function automatic logic [8:0] key_char(input logic [3:0] k);
        case (k)
            KEY_PAD1, KEY_PAD2, KEY_PAD3, KEY_PAD4: return 9'(k) + 9'd48;
            KEY_PAD6, KEY_PAD7, KEY_PAD8, KEY_PAD9: return 9'(k) + 9'd49;
            KEY_ESC:    return 9'd27;
            KEY_F5:     return 9'd319;
            KEY_PERIOD: return 9'd46;
            KEY_RETURN: return 9'd13;
            default:    return 9'd0;
        endcase
    endfunction

    function automatic int stick_step(input logic [7:0] v);
        if (v < reg_dead_lo) return int'(v) - int'(reg_dead_lo);
        if (v > reg_dead_hi) return int'(v) - int'(reg_dead_hi);
        return 0;
    endfunction

    function automatic int fit_axis(input int v, input logic [10:0] lim);
        int hi;
        hi = int'(lim) - 1;
        if (hi > 1023) hi = 1023;
        if (v > hi) v = hi;
        if (v < 0) v = 0;
        return v;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            CFG_SCREEN_W:   reg_screen_w   = val;
            CFG_SCREEN_H:   reg_screen_h   = val;
            CFG_OVERLAY_W:  reg_overlay_w  = val;
            CFG_OVERLAY_H:  reg_overlay_h  = val;
            CFG_OVERLAY_ON: reg_overlay_on = val[0];
            CFG_INTERVAL:   reg_interval   = val[9:0];
            CFG_DEAD_LO:    reg_dead_lo    = val[7:0];
            CFG_DEAD_HI:    reg_dead_hi    = val[7:0];
            default: ;
        endcase
    endfunction

    // next state and event word for one gamepad sample
    function automatic void convert_sample(input t_pad_sample s);
        logic [11:0] chg;
        logic        rt;
        logic [31:0] elapsed;
        int          nx, ny, ax, ay, px, py, sh;
        t_event_word w;
        chg = s.buttons ^ rec_buttons;
        rt  = s.buttons[BTN_RTRIG];
        nx  = 0;
        ny  = 0;
        w   = '0;
        if (s.buttons[BTN_UP]) begin
            ny++;
            if (rt) nx++;
        end
        if (s.buttons[BTN_RIGHT]) begin
            nx++;
            if (rt) ny--;
        end
        if (s.buttons[BTN_DOWN]) begin
            ny--;
            if (rt) nx--;
        end
        if (s.buttons[BTN_LEFT]) begin
            nx--;
            if (rt) ny++;
        end
        if (nx > 1) nx = 1; else if (nx < -1) nx = -1;
        if (ny > 1) ny = 1; else if (ny < -1) ny = -1;

        if (nx != held_x || ny != held_y) begin
            if (held_x == 0 && held_y == 0) begin
                w.kind = EV_KEY_DOWN;
                w.key  = pad_key_of(nx, ny);
                held_x = nx;
                held_y = ny;
            end else begin
                w.kind = EV_KEY_UP;
                w.key  = pad_key_of(held_x, held_y);
                held_x = 0;
                held_y = 0;
            end
            w.ascii = key_char(w.key);
            rec_buttons = s.buttons;
        end else if (chg[11:4] != '0) begin
            if (chg[BTN_CROSS]) begin
                w.kind = s.buttons[BTN_CROSS] ? EV_LEFT_DOWN : EV_LEFT_UP;
            end else if (chg[BTN_CIRCLE]) begin
                w.kind = s.buttons[BTN_CIRCLE] ? EV_RIGHT_DOWN : EV_RIGHT_UP;
            end else begin
                w.kind = ((chg & s.buttons) != '0) ? EV_KEY_DOWN : EV_KEY_UP;
                if (chg[BTN_LTRIG]) begin
                    w.key = KEY_ESC;
                end else if (chg[BTN_START]) begin
                    w.key  = KEY_F5;
                    w.ctrl = rt;
                end else if (chg[BTN_SQUARE]) begin
                    w.key = KEY_PERIOD;
                end else if (chg[BTN_TRIANGLE]) begin
                    w.key = KEY_RETURN;
                end else begin
                    w.shift = rt;
                end
                w.ascii = key_char(w.key);
            end
            rec_buttons = s.buttons;
        end else begin
            elapsed = s.now - last_check;
            if (elapsed <= {22'd0, reg_interval}) return;
            last_check = s.now;
            ax = stick_step(s.sx);
            ay = stick_step(s.sy);
            if (ax == 0 && ay == 0) return;
            rec_buttons = s.buttons;
            if (rt) begin
                px = cur_x + ((ax > 0) ? 1 : ((ax < 0) ? -1 : 0));
                py = cur_y + ((ay > 0) ? 1 : ((ay < 0) ? -1 : 0));
            end else begin
                sh = (reg_screen_w == WIDE_SCREEN_W) ? 2 : 3;
                px = cur_x + (ax >>> sh);
                py = cur_y + (ay >>> sh);
            end
            px = fit_axis(px, reg_overlay_on ? reg_overlay_w : reg_screen_w);
            py = fit_axis(py, reg_overlay_on ? reg_overlay_h : reg_screen_h);
            if (px == cur_x && py == cur_y) return;
            cur_x  = px;
            cur_y  = py;
            w.kind = EV_MOUSE_MOVE;
        end
        w.cx = 10'(cur_x);
        w.cy = 10'(cur_y);
        expected_events.push_back(w);
    endfunction

    task automatic push_sample(input logic [11:0] b, input logic [7:0] x,
                               input logic [7:0] y, input logic [31:0] dt);
        t_pad_sample s;
        clock_ms  = clock_ms + dt;
        s.buttons = b;
        s.sx      = x;
        s.sy      = y;
        s.now     = clock_ms;
        sample_queue.push_back(s);
    endtask

    function automatic logic [7:0] pick_axis();
        int v;
        case ($urandom_range(0, 4))
            0:       v = $urandom_range(0, 1) ? 255 : 0;
            1:       v = $urandom_range(0, 255);
            2:       v = int'(reg_dead_lo) - int'($urandom_range(0, 1));
            3:       v = int'(reg_dead_hi) + int'($urandom_range(0, 1));
            default: v = 128;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic push_random(input int count);
        int          r;
        logic [31:0] dt;
        logic [7:0]  x, y;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 50) pad_btn[$urandom_range(0, 11)] ^= 1'b1;
            else if (r < 60) pad_btn = 12'($urandom);
            x = pick_axis();
            y = pick_axis();
            r = $urandom_range(0, 99);
            if (r < 70) begin
                dt = $urandom_range(0, 2 * int'(reg_interval) + 10);
            end else if (r < 90) begin
                dt = {22'd0, reg_interval} + 32'($urandom_range(0, 1));
            end else if (r < 97) begin
                dt = $urandom_range(1000, 100000);
            end else begin
                clock_ms = $urandom;
                dt = '0;
            end
            push_sample(pad_btn, x, y, dt);
        end
    endtask

    task automatic program_regs();
        t_reg_write wr;
        while (reg_writes.size() != 0) begin
            wr = reg_writes.pop_front();
            cfg_if.valid <= 1'b1;
            cfg_if.index <= wr.idx;
            cfg_if.data  <= wr.val;
            do @(posedge i_clk); while (!cfg_if.ready);
            apply_reg(wr.idx, wr.val);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_queue.size() != 0 || smp_if.valid || expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sample driver and converter prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid       <= 1'b0;
            smp_if.button_bits <= '0;
            smp_if.stick_x     <= '0;
            smp_if.stick_y     <= '0;
            smp_if.now_ms      <= '0;
        end else begin
            if (smp_if.valid && smp_if.ready) convert_sample(cur_sample);
            if (!smp_if.valid || smp_if.ready) begin
                if (sample_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
                    cur_sample = sample_queue.pop_front();
                    smp_if.valid       <= 1'b1;
                    smp_if.button_bits <= cur_sample.buttons;
                    smp_if.stick_x     <= cur_sample.sx;
                    smp_if.stick_y     <= cur_sample.sy;
                    smp_if.now_ms      <= cur_sample.now;
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // event word monitor
    always @(posedge i_clk) begin
        t_event_word exp_w;
        t_event_word got_w;
        if (!i_rst_n) begin
            evt_if.ready <= 1'b0;
        end else begin
            if (evt_if.valid && evt_if.ready) begin
                got_w = '{evt_if.event_kind, evt_if.key_code, evt_if.ascii_code,
                          evt_if.flag_ctrl, evt_if.flag_shift, evt_if.cursor_x,
                          evt_if.cursor_y};
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected word: kind %0d key %0d ascii %0d ",
                                  "ctrl %0b shift %0b x %0d y %0d"},
                                 got_w.kind, got_w.key, got_w.ascii, got_w.ctrl,
                                 got_w.shift, got_w.cx, got_w.cy);
                end else begin
                    exp_w = expected_events.pop_front();
                    if (got_w.kind !== exp_w.kind || got_w.key !== exp_w.key ||
                        got_w.ascii !== exp_w.ascii || got_w.ctrl !== exp_w.ctrl ||
                        got_w.shift !== exp_w.shift || got_w.cx !== exp_w.cx ||
                        got_w.cy !== exp_w.cy) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"mismatch: expected kind %0d key %0d ascii %0d ",
                                      "ctrl %0b shift %0b x %0d y %0d"},
                                     exp_w.kind, exp_w.key, exp_w.ascii, exp_w.ctrl,
                                     exp_w.shift, exp_w.cx, exp_w.cy);
                            $display({"          actual   kind %0d key %0d ascii %0d ",
                                      "ctrl %0b shift %0b x %0d y %0d"},
                                     got_w.kind, got_w.key, got_w.ascii, got_w.ctrl,
                                     got_w.shift, got_w.cx, got_w.cy);
                        end
                    end
                end
            end
            evt_if.ready <= steady || ($urandom_range(0, 99) >= 29);
        end
    end

    // watchdog on cycles with no sample or register word taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_if.valid && smp_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("gamepad_to_key_mouse_events_unit_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // d-pad: plain, rotated, saturated, direct swap
        push_sample(12'd0, 8'd128, 8'd128, 32'd5);
        push_sample(M_UP, 8'd128, 8'd128, 32'd1);
        push_sample(M_UP | M_RTRIG, 8'd128, 8'd128, 32'd1);
        push_sample(M_UP | M_RTRIG, 8'd128, 8'd128, 32'd1);
        push_sample(M_UP | M_RIGHT | M_RTRIG, 8'd128, 8'd128, 32'd1);
        push_sample(M_UP | M_RIGHT | M_RTRIG, 8'd128, 8'd128, 32'd1);
        push_sample(M_LEFT, 8'd128, 8'd128, 32'd1);
        push_sample(M_LEFT, 8'd128, 8'd128, 32'd1);
        push_sample(M_DOWN | M_LEFT | M_RTRIG, 8'd128, 8'd128, 32'd1);
        push_sample(12'd0, 8'd128, 8'd128, 32'd1);
        push_sample(M_UP | M_DOWN, 8'd128, 8'd128, 32'd50);
        // mouse buttons and mapped keys
        push_sample(M_CROSS, 8'd128, 8'd128, 32'd1);
        push_sample(M_CIRCLE, 8'd128, 8'd128, 32'd1);
        push_sample(M_LTRIG, 8'd128, 8'd128, 32'd1);
        push_sample(M_START | M_RTRIG, 8'd128, 8'd128, 32'd1);
        push_sample(M_SQUARE | M_TRIANGLE | M_SELECT, 8'd128, 8'd128, 32'd1);
        push_sample(M_TRIANGLE, 8'd128, 8'd128, 32'd1);
        push_sample(M_RTRIG, 8'd128, 8'd128, 32'd1);
        // stick extremes, fine step, dead zone, time wrap
        push_sample(12'd0, 8'd0, 8'd0, 32'd41);
        push_sample(12'd0, 8'd255, 8'd255, 32'd41);
        push_sample(M_RTRIG, 8'd128, 8'd128, 32'd1);
        push_sample(M_RTRIG, 8'd0, 8'd255, 32'd41);
        push_sample(M_RTRIG, 8'd128, 8'd128, 32'd41);
        clock_ms = 32'hFFFF_FFF0;
        push_sample(M_RTRIG, 8'd0, 8'd0, 32'd0);
        push_sample(M_RTRIG, 8'd255, 8'd0, 32'd32);
        push_sample(M_RTRIG, 8'd255, 8'd0, 32'd9);
        pad_btn = M_RTRIG;
        push_random(PHASE_ITEMS);
        wait_idle();

        // wide screen, no interval, narrow dead zone
        reg_writes.push_back('{CFG_SCREEN_W, 11'd640});
        reg_writes.push_back('{CFG_SCREEN_H, 11'd480});
        reg_writes.push_back('{CFG_INTERVAL, 11'd0});
        reg_writes.push_back('{CFG_DEAD_LO, 11'd128});
        reg_writes.push_back('{CFG_DEAD_HI, 11'd128});
        program_regs();
        push_random(PHASE_ITEMS);
        wait_idle();

        // large overlay, longest interval, crossed dead zone, unused indexes
        steady = 1'b1;
        reg_writes.push_back('{CFG_OVERLAY_W, 11'd2047});
        reg_writes.push_back('{CFG_OVERLAY_H, 11'd1024});
        reg_writes.push_back('{CFG_OVERLAY_ON, 11'd1});
        reg_writes.push_back('{CFG_INTERVAL, 11'd1023});
        reg_writes.push_back('{CFG_DEAD_LO, 11'd255});
        reg_writes.push_back('{CFG_DEAD_HI, 11'd0});
        reg_writes.push_back('{CFG_UNUSED_LO, 11'h5A5});
        reg_writes.push_back('{CFG_UNUSED_HI, 11'h2DA});
        program_regs();
        push_random(PHASE_ITEMS);
        wait_idle();
        steady = 1'b0;

        // zero game surface
        reg_writes.push_back('{CFG_OVERLAY_ON, 11'd0});
        reg_writes.push_back('{CFG_SCREEN_W, 11'd0});
        reg_writes.push_back('{CFG_SCREEN_H, 11'd0});
        reg_writes.push_back('{CFG_INTERVAL, 11'd5});
        reg_writes.push_back('{CFG_DEAD_LO, 11'd100});
        reg_writes.push_back('{CFG_DEAD_HI, 11'd155});
        program_regs();
        push_random(PHASE_ITEMS);
        wait_idle();

        // one-pixel-wide overlay, dead zone from 0 to 200, time wrap
        reg_writes.push_back('{CFG_OVERLAY_ON, 11'd1});
        reg_writes.push_back('{CFG_OVERLAY_W, 11'd1});
        reg_writes.push_back('{CFG_OVERLAY_H, 11'd1024});
        reg_writes.push_back('{CFG_SCREEN_W, 11'd1});
        reg_writes.push_back('{CFG_INTERVAL, 11'd20});
        reg_writes.push_back('{CFG_DEAD_LO, 11'd0});
        reg_writes.push_back('{CFG_DEAD_HI, 11'd200});
        program_regs();
        clock_ms = 32'hFFFF_FC00;
        push_random(PHASE_ITEMS);
        wait_idle();

        // random register data
        for (int i = 0; i < 8; i++)
            reg_writes.push_back('{CFG_IDX_BITS'(i), CFG_DATA_BITS'($urandom)});
        program_regs();
        push_random(PHASE_ITEMS);
        wait_idle();

        // wide screen again, masked writes
        reg_writes.push_back('{CFG_SCREEN_W, 11'd640});
        reg_writes.push_back('{CFG_SCREEN_H, 11'd1});
        reg_writes.push_back('{CFG_OVERLAY_ON, 11'h7FE});
        reg_writes.push_back('{CFG_INTERVAL, 11'h40A});
        reg_writes.push_back('{CFG_DEAD_LO, 11'h164});
        reg_writes.push_back('{CFG_DEAD_HI, 11'h59B});
        program_regs();
        push_random(PHASE_ITEMS);
        wait_idle();

        if (mismatches == 0 && expected_events.size() == 0)
            $display("gamepad_to_key_mouse_events_unit_tb: PASS");
        else
            $display("gamepad_to_key_mouse_events_unit_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
design/gtkm_pkg.sv
design/gtkm_if.sv
design/gtkm_front.sv
design/gtkm_fifo.sv
design/gtkm_back.sv
design/gamepad_to_key_mouse_events_unit.sv
verif/gamepad_to_key_mouse_events_unit_tb.sv
